// File: rtl/tmbf_pkg.sv
// ----------------------------------------------------------------------------
// Tile map bucket fill: shared package
// Field widths, request and register codes, beat structs, neighbor table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmbf_pkg;

    // Fixed field widths
    localparam int POS_BITS      = 6;
    localparam int VALUE_BITS    = 16;
    localparam int COUNT_BITS    = 13;
    localparam int SIZE_REG_BITS = 7;
    localparam int APB_DATA_BITS = 32;
    localparam int PADDR_BITS    = 4;

    // Parameter defaults for the top level
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_ID_BITS    = 16;

    // Request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_FILL    = 2'd2;
    localparam logic [1:0] REQ_REPLACE = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CONNECTIVITY = 2'd2;

    // Register reset values
    localparam logic [SIZE_REG_BITS-1:0] RST_MAP_WIDTH    = 7'd24;
    localparam logic [SIZE_REG_BITS-1:0] RST_MAP_HEIGHT   = 7'd24;
    localparam logic                     RST_CONNECTIVITY = 1'b0;

    // Neighbor counts
    localparam logic [3:0] NDIR_FOUR  = 4'd4;
    localparam logic [3:0] NDIR_EIGHT = 4'd8;

    // Request beat
    typedef struct packed {
        logic [1:0]            req_type;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
        logic [VALUE_BITS-1:0] tile_value;
    } tmbf_req_t;

    // Result beat
    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [COUNT_BITS-1:0] changed_count;
        logic                  out_of_bounds;
    } tmbf_rsp_t;

    // Configuration as seen by the engine
    typedef struct packed {
        logic [SIZE_REG_BITS-1:0] map_width;
        logic [SIZE_REG_BITS-1:0] map_height;
        logic                     connectivity;
    } tmbf_cfg_t;

    // Queue commands from the engine
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } tmbf_qcmd_t;

    // One neighbor step
    typedef struct packed {
        logic xinc;
        logic xdec;
        logic yinc;
        logic ydec;
    } tmbf_dir_t;

    // Directions: right, left, down, up, then the four diagonals
    function automatic tmbf_dir_t tmbf_dir(input logic [2:0] d);
        tmbf_dir_t r;
        r = '0;
        case (d)
            3'd0:    r.xinc = 1'b1;
            3'd1:    r.xdec = 1'b1;
            3'd2:    r.yinc = 1'b1;
            3'd3:    r.ydec = 1'b1;
            3'd4:    begin r.xinc = 1'b1; r.yinc = 1'b1; end
            3'd5:    begin r.xinc = 1'b1; r.ydec = 1'b1; end
            3'd6:    begin r.xdec = 1'b1; r.yinc = 1'b1; end
            3'd7:    begin r.xdec = 1'b1; r.ydec = 1'b1; end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tmbf_cfg.sv
// ----------------------------------------------------------------------------
// Tile map bucket fill: configuration registers
// APB-style register file for map size and fill neighborhood.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmbf_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmbf_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [tmbf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tmbf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output tmbf_pkg::tmbf_cfg_t                 cfg
);
    import tmbf_pkg::*;

    logic [SIZE_REG_BITS-1:0] map_width_reg;
    logic [SIZE_REG_BITS-1:0] map_height_reg;
    logic                     connectivity_reg;
    logic [1:0]               reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= RST_MAP_WIDTH;
            map_height_reg   <= RST_MAP_HEIGHT;
            connectivity_reg <= RST_CONNECTIVITY;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAP_WIDTH:    map_width_reg    <= pwdata[SIZE_REG_BITS-1:0];
                REG_MAP_HEIGHT:   map_height_reg   <= pwdata[SIZE_REG_BITS-1:0];
                REG_CONNECTIVITY: connectivity_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_MAP_WIDTH:    prdata = APB_DATA_BITS'(map_width_reg);
            REG_MAP_HEIGHT:   prdata = APB_DATA_BITS'(map_height_reg);
            REG_CONNECTIVITY: prdata = APB_DATA_BITS'(connectivity_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.map_width    = map_width_reg;
    assign cfg.map_height   = map_height_reg;
    assign cfg.connectivity = connectivity_reg;

endmodule

`default_nettype wire

// File: rtl/tmbf_queue.sv
// ----------------------------------------------------------------------------
// Tile map bucket fill: pending queue
// FIFO of tile coordinates awaiting a neighbor visit during a flood fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmbf_queue #(
    parameter int ENTRY_BITS = $clog2(tmbf_pkg::DEF_MAX_WIDTH) +
                               $clog2(tmbf_pkg::DEF_MAX_HEIGHT),
    parameter int DEPTH      = tmbf_pkg::DEF_MAX_WIDTH * tmbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmbf_pkg::tmbf_qcmd_t   cmd,
    input  logic [ENTRY_BITS-1:0]  push_data,
    output logic [ENTRY_BITS-1:0]  pop_data,
    output logic                   empty
);
    import tmbf_pkg::*;

    localparam int QAB = $clog2(DEPTH);
    localparam int QCB = $clog2(DEPTH + 1);

    logic [ENTRY_BITS-1:0] q_mem [DEPTH];
    logic [ENTRY_BITS-1:0] pop_data_reg;
    logic [QCB-1:0]        head_reg;
    logic [QCB-1:0]        tail_reg;

    // Head and tail pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cmd.clear)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (cmd.push)
                tail_reg <= tail_reg + QCB'(1);
            if (cmd.pop)
                head_reg <= head_reg + QCB'(1);
        end
    end

    // Storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            q_mem[tail_reg[QAB-1:0]] <= push_data;
        if (cmd.pop)
            pop_data_reg <= q_mem[head_reg[QAB-1:0]];
    end

    assign pop_data = pop_data_reg;
    assign empty    = (head_reg == tail_reg);

endmodule

`default_nettype wire

// File: rtl/tmbf_engine.sv
// ----------------------------------------------------------------------------
// Tile map bucket fill: request engine
// Holds the tile map memory and sequences write, read, flood fill and
// global replace as read-modify-write passes over it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmbf_engine #(
    parameter int MAX_WIDTH  = tmbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tmbf_pkg::DEF_MAX_HEIGHT,
    parameter int ID_BITS    = tmbf_pkg::DEF_ID_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tmbf_pkg::tmbf_cfg_t       cfg,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  tmbf_pkg::tmbf_req_t       req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output tmbf_pkg::tmbf_rsp_t       rsp_data,
    output tmbf_pkg::tmbf_qcmd_t      q_cmd,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_push_data,
    input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_pop_data,
    input  logic                      q_empty
);
    import tmbf_pkg::*;

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AB    = $clog2(CELLS);
    localparam int SW    = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int CW    = ((SW > SIZE_REG_BITS) ? SW : SIZE_REG_BITS) + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_SEED,
        ST_POP,
        ST_LOAD,
        ST_NBR,
        ST_RESULT
    } state_t;

    // Tile map memory: {visited mark, tile id}
    logic [ID_BITS:0]   map_mem [CELLS];
    logic [ID_BITS:0]   mem_rdata_reg;
    logic               mem_re;
    logic [AB-1:0]      mem_raddr;
    logic               mem_we;
    logic [AB-1:0]      mem_waddr;
    logic [ID_BITS:0]   mem_wdata;

    // Control and datapath registers
    state_t                state_reg,     state_next;
    logic [1:0]            op_reg,        op_next;
    logic [ID_BITS-1:0]    val_reg,       val_next;
    logic [ID_BITS-1:0]    old_reg,       old_next;
    logic                  oob_reg,       oob_next;
    logic [XB-1:0]         seed_x_reg,    seed_x_next;
    logic [YB-1:0]         seed_y_reg,    seed_y_next;
    logic [COUNT_BITS-1:0] count_reg,     count_next;
    logic [XB-1:0]         sx_reg,        sx_next;
    logic [YB-1:0]         sy_reg,        sy_next;
    logic                  scan_run_reg,  scan_run_next;
    logic                  pend_reg,      pend_next;
    logic [XB-1:0]         pend_x_reg,    pend_x_next;
    logic [YB-1:0]         pend_y_reg,    pend_y_next;
    logic [XB-1:0]         cx_reg,        cx_next;
    logic [YB-1:0]         cy_reg,        cy_next;
    logic [3:0]            dir_reg,       dir_next;
    logic [AB-1:0]         clr_addr_reg,  clr_addr_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    tmbf_rsp_t             rsp_data_reg,  rsp_data_next;

    // Derived values
    logic [CW-1:0]         w_eff;
    logic [CW-1:0]         h_eff;
    logic [3:0]            ndirs;
    tmbf_dir_t             dir;
    logic [XB-1:0]         nb_x;
    logic [YB-1:0]         nb_y;
    logic                  nb_ok;
    logic                  dir_issue;
    logic                  scan_last_x;
    logic                  scan_last_y;
    logic [ID_BITS-1:0]    rd_id;
    logic                  rd_vis;
    logic                  rd_hit;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  req_oob;

    function automatic logic [AB-1:0] cell_addr(input logic [XB-1:0] x,
                                                input logic [YB-1:0] y);
        return AB'(AB'(y) * AB'(MAX_WIDTH)) + AB'(x);
    endfunction

    // Size registers saturate at the map maximum
    assign w_eff = (CW'(cfg.map_width) > CW'(MAX_WIDTH)) ?
                   CW'(MAX_WIDTH) : CW'(cfg.map_width);
    assign h_eff = (CW'(cfg.map_height) > CW'(MAX_HEIGHT)) ?
                   CW'(MAX_HEIGHT) : CW'(cfg.map_height);
    assign ndirs = cfg.connectivity ? NDIR_EIGHT : NDIR_FOUR;

    assign req_oob = (CW'(req_data.pos_x) >= w_eff) || (CW'(req_data.pos_y) >= h_eff);

    // Neighbor of the current center for the current direction
    always_comb
    begin
        dir       = tmbf_dir(dir_reg[2:0]);
        dir_issue = (dir_reg < ndirs);
        nb_x      = dir.xinc ? cx_reg + XB'(1) : (dir.xdec ? cx_reg - XB'(1) : cx_reg);
        nb_y      = dir.yinc ? cy_reg + YB'(1) : (dir.ydec ? cy_reg - YB'(1) : cy_reg);
        nb_ok     = (dir.xinc ? ((CW'(cx_reg) + CW'(1)) < w_eff) :
                     (dir.xdec ? (cx_reg != '0) : 1'b1)) &&
                    (dir.yinc ? ((CW'(cy_reg) + CW'(1)) < h_eff) :
                     (dir.ydec ? (cy_reg != '0) : 1'b1));
    end

    // Read data and shared helpers
    assign rd_id       = mem_rdata_reg[ID_BITS-1:0];
    assign rd_vis      = mem_rdata_reg[ID_BITS];
    assign rd_hit      = (rd_id == old_reg);
    assign count_inc   = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
    assign scan_last_x = (CW'(sx_reg) == (w_eff - CW'(1)));
    assign scan_last_y = (CW'(sy_reg) == (h_eff - CW'(1)));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        old_next       = old_reg;
        oob_next       = oob_reg;
        seed_x_next    = seed_x_reg;
        seed_y_next    = seed_y_reg;
        count_next     = count_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        scan_run_next  = scan_run_reg;
        pend_next      = pend_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dir_next       = dir_reg;
        clr_addr_next  = clr_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        mem_re      = 1'b0;
        mem_raddr   = cell_addr(seed_x_reg, seed_y_reg);
        mem_we      = 1'b0;
        mem_waddr   = cell_addr(pend_x_reg, pend_y_reg);
        mem_wdata   = '0;
        q_cmd       = '0;
        q_push_data = {pend_y_reg, pend_x_reg};

        // Result beat taken downstream
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            // Zero the whole map after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AB'(CELLS - 1))
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + AB'(1);
            end

            // Take a request and fetch the tile at its position
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req_data.req_type;
                    val_next    = ID_BITS'(req_data.tile_value);
                    seed_x_next = XB'(req_data.pos_x);
                    seed_y_next = YB'(req_data.pos_y);
                    count_next  = '0;
                    if (req_oob)
                    begin
                        oob_next   = 1'b1;
                        old_next   = '0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        oob_next   = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = cell_addr(XB'(req_data.pos_x), YB'(req_data.pos_y));
                        state_next = ST_LOOK;
                    end
                end
            end

            // Old id is back: dispatch on the request
            ST_LOOK:
            begin
                old_next   = rd_id;
                state_next = ST_RESULT;
                case (op_reg)
                    REQ_WRITE:
                    begin
                        if (rd_id != val_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cell_addr(seed_x_reg, seed_y_reg);
                            mem_wdata  = {1'b0, val_reg};
                            count_next = COUNT_BITS'(1);
                        end
                    end
                    REQ_FILL,
                    REQ_REPLACE:
                    begin
                        if (rd_id != val_reg)
                        begin
                            sx_next       = '0;
                            sy_next       = '0;
                            scan_run_next = 1'b1;
                            pend_next     = 1'b0;
                            q_cmd.clear   = (op_reg == REQ_FILL);
                            state_next    = ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end

            // Raster pass over the map in use: clear marks or replace ids
            ST_SCAN:
            begin
                if (scan_run_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = cell_addr(sx_reg, sy_reg);
                    pend_next   = 1'b1;
                    pend_x_next = sx_reg;
                    pend_y_next = sy_reg;
                    if (scan_last_x)
                    begin
                        sx_next = '0;
                        if (scan_last_y)
                            scan_run_next = 1'b0;
                        else
                            sy_next = sy_reg + YB'(1);
                    end
                    else
                        sx_next = sx_reg + XB'(1);
                end
                else
                    pend_next = 1'b0;

                if (pend_reg)
                begin
                    if (op_reg == REQ_FILL)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, rd_id};
                    end
                    else if (rd_hit)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {rd_vis, val_reg};
                        count_next = count_inc;
                    end
                    if (!scan_run_reg)
                        state_next = (op_reg == REQ_FILL) ? ST_SEED : ST_RESULT;
                end
            end

            // Recolor and mark the seed, queue it
            ST_SEED:
            begin
                mem_we      = 1'b1;
                mem_waddr   = cell_addr(seed_x_reg, seed_y_reg);
                mem_wdata   = {1'b1, val_reg};
                q_cmd.push  = 1'b1;
                q_push_data = {seed_y_reg, seed_x_reg};
                count_next  = COUNT_BITS'(1);
                state_next  = ST_POP;
            end

            // Next center from the queue, or done
            ST_POP:
            begin
                if (q_empty)
                    state_next = ST_RESULT;
                else
                begin
                    q_cmd.pop  = 1'b1;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                cx_next    = q_pop_data[XB-1:0];
                cy_next    = q_pop_data[XB+YB-1:XB];
                dir_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_NBR;
            end

            // Read one neighbor per cycle, resolve the previous one
            ST_NBR:
            begin
                pend_next = 1'b0;
                if (dir_issue)
                begin
                    dir_next = dir_reg + 4'd1;
                    if (nb_ok)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = cell_addr(nb_x, nb_y);
                        pend_next   = 1'b1;
                        pend_x_next = nb_x;
                        pend_y_next = nb_y;
                    end
                end
                else
                    state_next = ST_POP;

                if (pend_reg && !rd_vis)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, rd_hit ? val_reg : rd_id};
                    if (rd_hit)
                    begin
                        q_cmd.push = 1'b1;
                        count_next = count_inc;
                    end
                end
            end

            // Hand the result to the output register once it is free
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.read_value    = VALUE_BITS'(old_reg);
                    rsp_data_next.changed_count = count_reg;
                    rsp_data_next.out_of_bounds = oob_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= REQ_WRITE;
            val_reg       <= '0;
            old_reg       <= '0;
            oob_reg       <= 1'b0;
            seed_x_reg    <= '0;
            seed_y_reg    <= '0;
            count_reg     <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            scan_run_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            dir_reg       <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            old_reg       <= old_next;
            oob_reg       <= oob_next;
            seed_x_reg    <= seed_x_next;
            seed_y_reg    <= seed_y_next;
            count_reg     <= count_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            scan_run_reg  <= scan_run_next;
            pend_reg      <= pend_next;
            pend_x_reg    <= pend_x_next;
            pend_y_reg    <= pend_y_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            dir_reg       <= dir_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= map_mem[mem_raddr];
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// File: rtl/tile_map_bucket_fill_unit.sv
// ----------------------------------------------------------------------------
// Tile map bucket fill unit
// Tile id map with write, read, flood fill and global replace requests.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; every request returns one result beat.
// After reset the unit zeroes its map, one tile per cycle, over all
// MAX_WIDTH*MAX_HEIGHT tiles (4096 by default) with req_stall high.
// A write or read goes through the LOOK and RESULT states to the result
// register; an out-of-bounds request skips LOOK. Global replace scans the
// W*H tiles one tile per cycle through the single map memory port pair,
// where W and H are the map size in use. Flood fill first clears visit marks
// over the map in use, then reads the 4 or 8 neighbors of each recolored
// tile, one memory read per in-map neighbor; this loop sets the fill time.
// The next request is accepted as soon as the result is in the output
// register, even while it waits there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tile_map_bucket_fill_unit #(
    parameter int MAX_WIDTH  = tmbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tmbf_pkg::DEF_MAX_HEIGHT,
    parameter int ID_BITS    = tmbf_pkg::DEF_ID_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmbf_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [tmbf_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tmbf_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // Request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  tmbf_pkg::tmbf_req_t                 req_data,
    // Result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output tmbf_pkg::tmbf_rsp_t                 rsp_data
);
    import tmbf_pkg::*;

    localparam int QE_BITS = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

    tmbf_cfg_t          cfg;
    tmbf_qcmd_t         q_cmd;
    logic [QE_BITS-1:0] q_push_data;
    logic [QE_BITS-1:0] q_pop_data;
    logic               q_empty;

    // Register file
    tmbf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Fill queue
    tmbf_queue #(
        .ENTRY_BITS (QE_BITS),
        .DEPTH      (MAX_WIDTH * MAX_HEIGHT)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .push_data (q_push_data),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Map memory and request sequencer
    tmbf_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ID_BITS    (ID_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .q_cmd       (q_cmd),
        .q_push_data (q_push_data),
        .q_pop_data  (q_pop_data),
        .q_empty     (q_empty)
    );

endmodule

`default_nettype wire
